// ----- sv/sitda_pkg.sv -----
// Shared types and character constants for the signed integer to decimal text converter.
package sitda_pkg;

   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   // decimal digits needed for any w-bit unsigned value (1233/4096 ~ log10(2))
   function automatic int sitda_digits(input int w);
      return ((w * 1233) >>> 12) + 1;
   endfunction

   typedef struct packed {
      logic load;        // capture sign and magnitude, clear BCD
      logic dabble;      // one double dabble step
      logic emit;        // pop the top BCD digit
      logic last_digit;  // popped digit is the units digit
      logic newline;     // emit the end-of-run character
   } sitda_cmd_type;

endpackage

// ----- sv/sitda_ctrl.sv -----
// Sequencer: accept, conversion steps, digit pops, newline.
module sitda_ctrl #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output sitda_pkg::sitda_cmd_type cmd
);
   import sitda_pkg::*;

   localparam int NDIG  = sitda_digits(VALUE_WIDTH);
   localparam int BCNT_W = $clog2(VALUE_WIDTH);
   localparam int DCNT_W = $clog2(NDIG);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CONV  = 2'd1;
   localparam logic [1:0] S_DIGIT = 2'd2;
   localparam logic [1:0] S_NL    = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   always_comb begin
      state_in = state_ff;
      bcnt_in  = bcnt_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               bcnt_in  = BCNT_W'(VALUE_WIDTH - 1);
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.dabble = 1'b1;
            if (bcnt_ff == '0) begin
               dcnt_in  = DCNT_W'(NDIG - 1);
               state_in = S_DIGIT;
            end else begin
               bcnt_in = bcnt_ff - 1'b1;
            end
         end
         S_DIGIT: begin
            cmd.emit       = 1'b1;
            cmd.last_digit = (dcnt_ff == '0);
            if (dcnt_ff == '0) begin
               state_in = S_NL;
            end else begin
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         S_NL: begin
            cmd.newline = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bcnt_ff <= bcnt_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

// ----- sv/sitda_dp.sv -----
// Datapath: magnitude shifter, bit-serial double dabble register, output beat register.
module sitda_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sitda_pkg::sitda_cmd_type cmd,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_character,
   output logic                     rsp_last
);
   import sitda_pkg::*;

   localparam int NDIG  = sitda_digits(VALUE_WIDTH);
   localparam int BCD_W = 4 * NDIG;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic                   seen_ff, seen_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic [VALUE_WIDTH-1:0] value_u;
   logic [3:0]             top_digit;

   assign value_u   = VALUE_WIDTH'(unsigned'(req_value));
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      seen_in  = seen_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = 1'b0;
      if (cmd.load) begin
         mag_in   = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
         bcd_in   = '0;
         seen_in  = 1'b0;
         valid_in = value_u[VALUE_WIDTH-1];
         char_in  = CHAR_MINUS;
      end else if (cmd.dabble) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (cmd.emit) begin
         // leading zeros are dropped, the units digit always goes out
         valid_in = seen_ff || (top_digit != 4'd0) || cmd.last_digit;
         seen_in  = valid_in;
         char_in  = CHAR_ZERO + {4'b0000, top_digit};
         bcd_in   = {bcd_ff[BCD_W-5:0], 4'b0000};
      end else if (cmd.newline) begin
         valid_in = 1'b1;
         char_in  = CHAR_NEWLINE;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      seen_ff <= seen_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// Top level: signed integer to decimal ASCII text, one character per beat.
//
// Input: drive req_value and raise start; the beat is taken at a rising edge
// where start is high and busy is low. busy stays high until the run ends.
// Output: one character per beat on rsp_character, qualified by rsp_valid for
// exactly one cycle; rsp_last marks the closing newline. The receiver cannot
// stall, so every beat must be taken when shown.
// Run: optional '-', digits most significant first without leading zeros,
// then newline (10). Zero prints "0". The most negative value prints exactly.
// Timing: after the accept edge busy covers one double dabble step per
// magnitude bit, then one BCD digit popped per cycle for all NDIG digits, where
// NDIG is the decimal digit count of a VALUE_WIDTH-bit word (10 at 32 bits),
// then the newline. A new value is taken only once busy is low again. The
// '-' appears the cycle after the accept; the newline shows in the first
// cycle with busy low.
// Reset: synchronous, active high; returns to idle and drops rsp_valid.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last
);
   import sitda_pkg::*;

   sitda_cmd_type cmd;

   sitda_ctrl #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sitda_dp #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character == CHAR_NEWLINE)
      else $error("last beat is not a newline");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after accept");

   a_first_beat_sign: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid || rsp_character == CHAR_MINUS)
      else $error("unexpected beat after accept");

   a_newline_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_character != CHAR_NEWLINE)
      else $error("newline before end of run");

endmodule
